FILE: sv/knp_pkg.sv
// ----------------------------------------------------------------------------
// knp_pkg: shared constants and types for the knapsack solver
// Sizes of the row store, the taken-bit store and the item store, payload
// structs of both channels, internal control structs and state encodings.
// ----------------------------------------------------------------------------
package knp_pkg;

    // Sizing
    localparam int MAX_ITEMS    = 32;
    localparam int MAX_CAPACITY = 1024;
    localparam int VALUE_BITS   = 16;

    // Fixed field widths of the ports
    localparam int WEIGHT_W  = 12;
    localparam int VALUE_W   = 16;
    localparam int CAP_W     = 10;
    localparam int INDEX_W   = 5;
    localparam int TOTAL_V_W = 21;
    localparam int TOTAL_W_W = 10;

    // Derived widths
    localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int COL_W      = $clog2(MAX_CAPACITY);
    localparam int ROW_W      = VALUE_BITS + IDX_W;
    localparam int CMP_W      = (COL_W > WEIGHT_W) ? COL_W : WEIGHT_W;
    localparam int BIT_ADDR_W = IDX_W + COL_W;

    typedef struct packed {
        logic [WEIGHT_W-1:0] item_weight;
        logic [VALUE_W-1:0]  item_value;
        logic                item_last;
    } t_item;

    typedef struct packed {
        logic [INDEX_W-1:0]   chosen_index;
        logic [WEIGHT_W-1:0]  chosen_weight;
        logic [VALUE_W-1:0]   chosen_value;
        logic [TOTAL_V_W-1:0] value_sum;
        logic [TOTAL_W_W-1:0] weight_sum;
        logic                 none_chosen;
        logic                 overflow;
        logic                 result_last;
    } t_result;

    typedef struct packed {
        logic [WEIGHT_W-1:0]   weight;
        logic [VALUE_BITS-1:0] value;
    } t_item_rec;

    typedef struct packed {
        logic                  sweep;
        logic                  clear;
        logic [WEIGHT_W-1:0]   weight;
        logic [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]      item;
    } t_sweep_req;

    typedef struct packed {
        logic                  we;
        logic [BIT_ADDR_W-1:0] addr;
        logic                  data;
    } t_bit_wr;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] count;
        logic [COL_W-1:0] cap;
        logic             ovf;
    } t_trace_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_TRACE
    } t_top_state;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_SWEEP,
        SW_DRAIN,
        SW_CLEAR
    } t_sweep_state;

    typedef enum logic [1:0] {
        TR_IDLE,
        TR_READ,
        TR_EVAL,
        TR_FLUSH
    } t_trace_state;

endpackage

FILE: sv/knp_ram.sv
// ----------------------------------------------------------------------------
// knp_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module knp_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/knp_sweep.sv
// ----------------------------------------------------------------------------
// knp_sweep: best-value row sweep and clearing pass
// Walks all columns from the top down, one per cycle, reading the row at
// the column and at the column minus the item weight, and writes back the
// improved value plus one taken bit per column. Also zeroes the row.
// ----------------------------------------------------------------------------
module knp_sweep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  knp_pkg::t_sweep_req  i_req,
    output knp_pkg::t_bit_wr     o_bit_wr,
    output logic                 o_done
);

    knp_pkg::t_sweep_state r_state, n_state;

    logic [knp_pkg::COL_W-1:0]    r_col, n_col;
    logic [knp_pkg::WEIGHT_W-1:0] r_wt, n_wt;
    logic [knp_pkg::ROW_W-1:0]    r_val, n_val;
    logic [knp_pkg::IDX_W-1:0]    r_item, n_item;

    // stage 1: column whose row data returns this cycle
    logic                      r_s1_valid;
    logic [knp_pkg::COL_W-1:0] r_s1_col;
    logic                      r_s1_fits;

    logic [knp_pkg::COL_W-1:0] raddr_b;
    logic [knp_pkg::ROW_W-1:0] rd_a, rd_b, cand;
    logic                      take;
    logic                      row_we;
    logic [knp_pkg::COL_W-1:0] row_waddr;
    logic [knp_pkg::ROW_W-1:0] row_wdata;

    // Two copies of the row give two read ports; both take every write.
    knp_ram #(.ADDR_W(knp_pkg::COL_W), .DATA_W(knp_pkg::ROW_W)) u_row_a (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (r_col),
        .o_rdata (rd_a)
    );

    knp_ram #(.ADDR_W(knp_pkg::COL_W), .DATA_W(knp_pkg::ROW_W)) u_row_b (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    assign raddr_b = knp_pkg::COL_W'(knp_pkg::CMP_W'(r_col) - knp_pkg::CMP_W'(r_wt));
    assign cand    = rd_b + r_val;
    assign take    = r_s1_valid && r_s1_fits && (rd_a < cand);

    assign o_bit_wr.we   = r_s1_valid;
    assign o_bit_wr.addr = {r_item, r_s1_col};
    assign o_bit_wr.data = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= knp_pkg::SW_CLEAR;
            r_col      <= knp_pkg::COL_W'(knp_pkg::MAX_CAPACITY - 1);
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_s1_valid <= (r_state == knp_pkg::SW_SWEEP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wt      <= n_wt;
        r_val     <= n_val;
        r_item    <= n_item;
        r_s1_col  <= r_col;
        r_s1_fits <= (knp_pkg::CMP_W'(r_col) >= knp_pkg::CMP_W'(r_wt));
    end

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_wt      = r_wt;
        n_val     = r_val;
        n_item    = r_item;
        o_done    = 1'b0;
        row_we    = take;
        row_waddr = r_s1_col;
        row_wdata = cand;
        case (r_state)
            knp_pkg::SW_IDLE: begin
                if (i_req.clear) begin
                    n_col   = knp_pkg::COL_W'(knp_pkg::MAX_CAPACITY - 1);
                    n_state = knp_pkg::SW_CLEAR;
                end else if (i_req.sweep) begin
                    n_wt    = i_req.weight;
                    n_val   = knp_pkg::ROW_W'(i_req.value);
                    n_item  = i_req.item;
                    n_col   = knp_pkg::COL_W'(knp_pkg::MAX_CAPACITY - 1);
                    n_state = knp_pkg::SW_SWEEP;
                end
            end
            knp_pkg::SW_SWEEP: begin
                if (r_col == '0) begin
                    n_state = knp_pkg::SW_DRAIN;
                end else begin
                    n_col = r_col - 1'b1;
                end
            end
            knp_pkg::SW_DRAIN: begin
                // column zero retires this cycle
                o_done  = 1'b1;
                n_state = knp_pkg::SW_IDLE;
            end
            knp_pkg::SW_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = r_col;
                row_wdata = '0;
                if (r_col == '0) begin
                    o_done  = 1'b1;
                    n_state = knp_pkg::SW_IDLE;
                end else begin
                    n_col = r_col - 1'b1;
                end
            end
            default: begin
                n_state = knp_pkg::SW_IDLE;
            end
        endcase
    end

    a_s1_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == knp_pkg::SW_SWEEP || r_state == knp_pkg::SW_DRAIN))
        else $error("row update pending outside a sweep");

    a_drain_ends_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == knp_pkg::SW_DRAIN) |-> (r_s1_valid && r_s1_col == '0))
        else $error("sweep drained before column zero");

endmodule

FILE: sv/knp_trace.sv
// ----------------------------------------------------------------------------
// knp_trace: traceback over the taken bits
// Walks the stored items from last to first, reading then evaluating each,
// and emits one result per taken item through a one-deep hold so the final
// result can carry the last flag. Emits a single none-chosen result otherwise.
// ----------------------------------------------------------------------------
module knp_trace (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  knp_pkg::t_trace_cmd                i_cmd,
    output logic [knp_pkg::BIT_ADDR_W-1:0]     o_bit_raddr,
    input  logic                               i_bit_rdata,
    output logic [knp_pkg::IDX_W-1:0]          o_item_raddr,
    input  knp_pkg::t_item_rec                 i_item_rdata,
    output logic                               o_strobe,
    output knp_pkg::t_result                   o_result,
    output logic                               o_done
);

    knp_pkg::t_trace_state r_state, n_state;

    logic [knp_pkg::IDX_W-1:0]     r_n, n_n;
    logic [knp_pkg::COL_W-1:0]     r_w, n_w;
    logic [knp_pkg::TOTAL_V_W-1:0] r_tv, n_tv;
    logic [knp_pkg::TOTAL_W_W-1:0] r_tw, n_tw;
    logic                          r_ovf, n_ovf;
    logic                          r_pend_valid, n_pend_valid;
    knp_pkg::t_result              r_pend, n_pend;
    logic                          r_strobe, n_strobe;
    knp_pkg::t_result              r_out, n_out;

    assign o_bit_raddr  = {r_n, r_w};
    assign o_item_raddr = r_n;
    assign o_strobe     = r_strobe;
    assign o_result     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= knp_pkg::TR_IDLE;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_w    <= n_w;
        r_tv   <= n_tv;
        r_tw   <= n_tw;
        r_ovf  <= n_ovf;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_w          = r_w;
        n_tv         = r_tv;
        n_tw         = r_tw;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_strobe     = 1'b0;
        n_out        = r_out;
        o_done       = 1'b0;
        case (r_state)
            knp_pkg::TR_IDLE: begin
                if (i_cmd.go) begin
                    n_w          = i_cmd.cap;
                    n_ovf        = i_cmd.ovf;
                    n_tv         = '0;
                    n_tw         = '0;
                    n_pend_valid = 1'b0;
                    n_n          = knp_pkg::IDX_W'(i_cmd.count - 1'b1);
                    n_state      = (i_cmd.count == '0) ? knp_pkg::TR_FLUSH : knp_pkg::TR_READ;
                end
            end
            knp_pkg::TR_READ: begin
                n_state = knp_pkg::TR_EVAL;
            end
            knp_pkg::TR_EVAL: begin
                if (i_bit_rdata) begin
                    // release the held result, hold the new one
                    if (r_pend_valid) begin
                        n_strobe = 1'b1;
                        n_out    = r_pend;
                    end
                    n_tv = r_tv + knp_pkg::TOTAL_V_W'(i_item_rdata.value);
                    n_tw = r_tw + knp_pkg::TOTAL_W_W'(i_item_rdata.weight);
                    if (knp_pkg::CMP_W'(i_item_rdata.weight) <= knp_pkg::CMP_W'(r_w)) begin
                        n_w = knp_pkg::COL_W'(knp_pkg::CMP_W'(r_w)
                                              - knp_pkg::CMP_W'(i_item_rdata.weight));
                    end else begin
                        n_w = '0;
                    end
                    n_pend_valid         = 1'b1;
                    n_pend.chosen_index  = knp_pkg::INDEX_W'(r_n);
                    n_pend.chosen_weight = i_item_rdata.weight;
                    n_pend.chosen_value  = knp_pkg::VALUE_W'(i_item_rdata.value);
                    n_pend.value_sum     = n_tv;
                    n_pend.weight_sum    = n_tw;
                    n_pend.none_chosen   = 1'b0;
                    n_pend.overflow      = r_ovf;
                    n_pend.result_last   = 1'b0;
                end
                if (r_n == '0) begin
                    n_state = knp_pkg::TR_FLUSH;
                end else begin
                    n_n     = r_n - 1'b1;
                    n_state = knp_pkg::TR_READ;
                end
            end
            knp_pkg::TR_FLUSH: begin
                n_strobe = 1'b1;
                if (r_pend_valid) begin
                    n_out             = r_pend;
                    n_out.result_last = 1'b1;
                end else begin
                    n_out             = '0;
                    n_out.none_chosen = 1'b1;
                    n_out.overflow    = r_ovf;
                    n_out.result_last = 1'b1;
                end
                n_pend_valid = 1'b0;
                o_done       = 1'b1;
                n_state      = knp_pkg::TR_IDLE;
            end
            default: begin
                n_state = knp_pkg::TR_IDLE;
            end
        endcase
    end

    a_done_gives_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (o_strobe && o_result.result_last))
        else $error("traceback finished without a final result");

    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.result_last) |=> !o_strobe)
        else $error("result emitted after the final result");

endmodule

FILE: sv/knapsack_dp_solver.sv
// ----------------------------------------------------------------------------
// knapsack_dp_solver: 0/1 knapsack solver by dynamic programming
// Takes items one at a time, sweeps a best-value row per item, and on the
// item marked last traces back the chosen items and reports them.
// ----------------------------------------------------------------------------
// Usage: write the capacity over the configuration channel while the block
// is idle, then issue items with start while busy is low. Each stored item
// keeps busy high while the row store is swept one column per cycle over
// all 1024 columns through its read ports, plus a drain step to retire the
// last column; no new item is taken before that. An item arriving when
// 32 items are already stored is dropped and flags overflow. On the last
// item the traceback reads and evaluates each stored item in turn, then
// flushes; results appear on o_result for exactly one cycle each, marked by
// o_strobe; they cannot be held off, so capture every strobed transaction.
// Results come last-loaded first with running totals; result_last marks
// the final one. When nothing fits, a single none-chosen result is given.
// After every answer, and after reset, the row store is zeroed in a clearing
// pass over all 1024 columns during which busy stays high; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
module knapsack_dp_solver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  knp_pkg::t_item                i_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [knp_pkg::CAP_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output knp_pkg::t_result              o_result
);

    knp_pkg::t_top_state r_state, n_state;

    logic [knp_pkg::CAP_W-1:0] r_cap;
    logic [knp_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_dropped, n_dropped;
    logic                      r_last, n_last;

    logic [knp_pkg::COL_W-1:0] cap_eff;

    knp_pkg::t_sweep_req  sweep_req;
    knp_pkg::t_bit_wr     bit_wr;
    logic                 sweep_done;
    knp_pkg::t_trace_cmd  trace_cmd;
    logic                 trace_done;

    logic                               item_we;
    knp_pkg::t_item_rec                 item_wdata;
    logic [knp_pkg::IDX_W-1:0]          item_raddr;
    knp_pkg::t_item_rec                 item_rdata;
    logic [knp_pkg::BIT_ADDR_W-1:0]     bit_raddr;
    logic                               bit_rdata;

    // Clamp capacity to the top column of the row store.
    assign cap_eff = (32'(r_cap) > knp_pkg::MAX_CAPACITY - 1)
                   ? knp_pkg::COL_W'(knp_pkg::MAX_CAPACITY - 1)
                   : knp_pkg::COL_W'(r_cap);

    assign o_cfg_ready = 1'b1;

    assign item_wdata.weight = i_item.item_weight;
    assign item_wdata.value  = i_item.item_value[knp_pkg::VALUE_BITS-1:0];

    // Row sweep engine, owns the best-value row.
    knp_sweep u_sweep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (sweep_req),
        .o_bit_wr (bit_wr),
        .o_done   (sweep_done)
    );

    // Taken bits, one per (item, column).
    knp_ram #(.ADDR_W(knp_pkg::BIT_ADDR_W), .DATA_W(1)) u_taken (
        .i_clk   (i_clk),
        .i_we    (bit_wr.we),
        .i_waddr (bit_wr.addr),
        .i_wdata (bit_wr.data),
        .i_raddr (bit_raddr),
        .o_rdata (bit_rdata)
    );

    // Stored item weights and values.
    knp_ram #(.ADDR_W(knp_pkg::IDX_W), .DATA_W($bits(knp_pkg::t_item_rec))) u_items (
        .i_clk   (i_clk),
        .i_we    (item_we),
        .i_waddr (r_count[knp_pkg::IDX_W-1:0]),
        .i_wdata (item_wdata),
        .i_raddr (item_raddr),
        .o_rdata (item_rdata)
    );

    knp_trace u_trace (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (trace_cmd),
        .o_bit_raddr  (bit_raddr),
        .i_bit_rdata  (bit_rdata),
        .o_item_raddr (item_raddr),
        .i_item_rdata (item_rdata),
        .o_strobe     (o_strobe),
        .o_result     (o_result),
        .o_done       (trace_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= knp_pkg::ST_CLEAR;
            r_cap     <= '0;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_last    <= n_last;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_dropped       = r_dropped;
        n_last          = r_last;
        busy            = 1'b1;
        item_we         = 1'b0;
        sweep_req       = '0;
        sweep_req.weight = i_item.item_weight;
        sweep_req.value  = i_item.item_value[knp_pkg::VALUE_BITS-1:0];
        sweep_req.item   = r_count[knp_pkg::IDX_W-1:0];
        trace_cmd       = '0;
        trace_cmd.count = r_count;
        trace_cmd.cap   = cap_eff;
        trace_cmd.ovf   = r_dropped;
        case (r_state)
            knp_pkg::ST_CLEAR: begin
                // hold off items until the row is zero
                if (sweep_done) begin
                    n_state = knp_pkg::ST_IDLE;
                end
            end
            knp_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_last = i_item.item_last;
                    if (r_count < knp_pkg::CNT_W'(knp_pkg::MAX_ITEMS)) begin
                        item_we         = 1'b1;
                        sweep_req.sweep = 1'b1;
                        n_count         = r_count + 1'b1;
                        n_state         = knp_pkg::ST_SWEEP;
                    end else begin
                        // drop the item; a last mark still starts the answer
                        n_dropped = 1'b1;
                        if (i_item.item_last) begin
                            trace_cmd.go  = 1'b1;
                            trace_cmd.ovf = 1'b1;
                            n_state       = knp_pkg::ST_TRACE;
                        end
                    end
                end
            end
            knp_pkg::ST_SWEEP: begin
                if (sweep_done) begin
                    if (r_last) begin
                        trace_cmd.go = 1'b1;
                        n_state      = knp_pkg::ST_TRACE;
                    end else begin
                        n_state = knp_pkg::ST_IDLE;
                    end
                end
            end
            knp_pkg::ST_TRACE: begin
                if (trace_done) begin
                    // answer out: drop the set and zero the row
                    n_count         = '0;
                    n_dropped       = 1'b0;
                    sweep_req.clear = 1'b1;
                    n_state         = knp_pkg::ST_CLEAR;
                end
            end
            default: begin
                n_state = knp_pkg::ST_CLEAR;
            end
        endcase
    end

    a_results_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result emitted while the block reports idle");

    a_full_set_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && r_count == knp_pkg::CNT_W'(knp_pkg::MAX_ITEMS)
         && !i_item.item_last) |=> (r_dropped && r_count == $past(r_count)))
        else $error("item beyond the store limit was not dropped");

endmodule

FILE: tb/sv/knapsack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knapsack_checker: result predictor and scoreboard for the knapsack solver
// Watches the item, capacity and result channels and keeps its own copy of
// the best-value row, the taken bits and the stored items. It predicts the
// chosen items for every set and compares each result transaction field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module knapsack_checker
    import knp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_item            i_item,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_strobe,
    input  t_result          i_result,
    output int               o_errors,
    output int               o_pending,
    output int               o_results,
    output int               o_none_results
);

    logic [TOTAL_V_W-1:0] best_value [MAX_CAPACITY];
    bit                   took [MAX_ITEMS][MAX_CAPACITY];
    logic [WEIGHT_W-1:0]  held_weight [MAX_ITEMS];
    logic [VALUE_W-1:0]   held_value [MAX_ITEMS];
    int                   held_count = 0;
    bit                   lost_item = 1'b0;
    logic [CAP_W-1:0]     capacity = '0;
    t_result              picks_q[$];

    int mismatch_count = 0;
    int pending_count  = 0;
    int result_count   = 0;
    int none_count     = 0;

    assign o_errors       = mismatch_count;
    assign o_pending      = pending_count;
    assign o_results      = result_count;
    assign o_none_results = none_count;

    task automatic clear_set();
        for (int j = 0; j < MAX_CAPACITY; j++) begin
            best_value[j] = '0;
        end
        held_count = 0;
        lost_item  = 1'b0;
    endtask

    // Walk back from the newest stored item, starting at the capacity column.
    task automatic trace_choices();
        int                   col;
        int                   n_out;
        logic [TOTAL_V_W-1:0] sum_v;
        logic [TOTAL_W_W-1:0] sum_w;
        t_result              r;
        col   = int'(capacity);
        sum_v = '0;
        sum_w = '0;
        n_out = 0;
        for (int n = held_count - 1; n >= 0; n--) begin
            if (took[n][col]) begin
                col   = (int'(held_weight[n]) <= col) ? col - int'(held_weight[n]) : 0;
                sum_v = sum_v + TOTAL_V_W'(held_value[n]);
                sum_w = sum_w + TOTAL_W_W'(held_weight[n]);
                r               = '0;
                r.chosen_index  = INDEX_W'(n);
                r.chosen_weight = held_weight[n];
                r.chosen_value  = held_value[n];
                r.value_sum     = sum_v;
                r.weight_sum    = sum_w;
                r.overflow      = lost_item;
                picks_q.push_back(r);
                n_out++;
            end
        end
        if (n_out == 0) begin
            r             = '0;
            r.none_chosen = 1'b1;
            r.overflow    = lost_item;
            r.result_last = 1'b1;
            picks_q.push_back(r);
        end else begin
            r             = picks_q.pop_back();
            r.result_last = 1'b1;
            picks_q.push_back(r);
        end
        clear_set();
    endtask

    // Sweep all columns high to low; take the item only on strict gain.
    task automatic absorb_item(input t_item it);
        int                 wt;
        logic [TOTAL_V_W:0] cand;
        wt = int'(it.item_weight);
        if (held_count < MAX_ITEMS) begin
            held_weight[held_count] = it.item_weight;
            held_value[held_count]  = it.item_value;
            for (int j = MAX_CAPACITY - 1; j >= 0; j--) begin
                took[held_count][j] = 1'b0;
                if (j >= wt) begin
                    cand = {1'b0, best_value[j - wt]} + (TOTAL_V_W + 1)'(it.item_value);
                    if (cand > {1'b0, best_value[j]}) begin
                        best_value[j]       = cand[TOTAL_V_W-1:0];
                        took[held_count][j] = 1'b1;
                    end
                end
            end
            held_count++;
        end else begin
            lost_item = 1'b1;
        end
        if (it.item_last) begin
            trace_choices();
        end
    endtask

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: result %0d field %s: expected %0d, got %0d",
                         $realtime, result_count, fname, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_set();
            capacity = '0;
            picks_q.delete();
        end else begin
            if (i_strobe) begin
                result_count++;
                if (i_result.none_chosen === 1'b1) begin
                    none_count++;
                end
                if (picks_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected result transaction %h",
                                 $realtime, i_result);
                    end
                end else begin
                    want = picks_q.pop_front();
                    check_field("chosen_index",  want.chosen_index,  i_result.chosen_index);
                    check_field("chosen_weight", want.chosen_weight, i_result.chosen_weight);
                    check_field("chosen_value",  want.chosen_value,  i_result.chosen_value);
                    check_field("value_sum",     want.value_sum,     i_result.value_sum);
                    check_field("weight_sum",    want.weight_sum,    i_result.weight_sum);
                    check_field("none_chosen",   want.none_chosen,   i_result.none_chosen);
                    check_field("overflow",      want.overflow,      i_result.overflow);
                    check_field("result_last",   want.result_last,   i_result.result_last);
                end
            end
            if (i_start && !i_busy) begin
                absorb_item(i_item);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
        end
        pending_count = picks_q.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the knapsack solver
// Runs a short directed list of item sets (fit at zero capacity, items too
// heavy, zero values, ties, a capacity change inside a set), then random
// sets of mixed length, including full sets, sets that overflow the item
// store and sets of weightless top-value items. A checker beside the block
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module testbench;
    import knp_pkg::*;

    localparam int ITEM_GOAL   = 420;
    localparam int SETTLE_GAP  = 4;     // cycles to let the block leave a result burst
    localparam int TAIL_CYCLES = 2200;  // traceback plus clearing pass, with margin

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    t_item               item_bus    = '0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data    = '0;
    logic                strobe;
    t_result             result_bus;

    int fail_count;
    int pending;
    int result_total;
    int none_total;

    // Stimulus bookkeeping
    int               idle_pct   = 30;
    int               items_sent = 0;
    int               sets_sent  = 0;
    int               cfg_writes = 0;
    logic [CAP_W-1:0] cap_now    = '0;

    always #10 clk = ~clk;

    knapsack_dp_solver i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (item_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_strobe    (strobe),
        .o_result    (result_bus)
    );

    knapsack_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item_bus),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .i_strobe       (strobe),
        .i_result       (result_bus),
        .o_errors       (fail_count),
        .o_pending      (pending),
        .o_results      (result_total),
        .o_none_results (none_total)
    );

    // Offer one item and hold it until the block takes it. Start may drop
    // for random cycles while waiting, so idle gaps land both inside the
    // sweep and right where busy falls.
    task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                             input bit last);
        t_item it;
        bit    offered;
        it.item_weight = w;
        it.item_value  = v;
        it.item_last   = last;
        offered  = ($urandom_range(99) >= idle_pct);
        start    <= offered;
        item_bus <= it;
        forever begin
            @(posedge clk);
            if (offered && !busy) begin
                break;
            end
            offered = ($urandom_range(99) >= idle_pct);
            start   <= offered;
        end
        items_sent++;
    endtask

    // Hold the sender until every predicted result has arrived and the
    // block has gone idle again (clearing pass or sweep finished).
    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_GAP) @(negedge clk);
        while (busy) begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Write the capacity register; only called while the block is idle.
    task automatic write_capacity(input logic [CAP_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do begin
            @(posedge clk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_now = c;
        cfg_writes++;
    endtask

    initial begin
        int               set_len;
        int               set_kind;
        int               split_at;
        logic [WEIGHT_W-1:0] w;
        logic [VALUE_W-1:0]  v;

        // Hold reset, then release it; the block clears its row store
        // afterwards with busy high, which the handshake absorbs.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed sets ----------------
        // Weightless item at the reset capacity of zero: it fits.
        send_item(12'd0, 16'd5, 1'b1);
        settle();
        sets_sent++;

        // Heaviest item never fits, even at the largest capacity.
        write_capacity(10'd1023);
        send_item(12'hFFF, 16'hFFFF, 1'b1);
        settle();
        sets_sent++;

        // Item filling the whole capacity, then a zero-value item that
        // brings no strict gain.
        send_item(12'd1023, 16'hFFFF, 1'b0);
        send_item(12'd0, 16'd0, 1'b1);
        settle();
        sets_sent++;

        // Tie: the second identical item must not replace the first.
        write_capacity(10'd5);
        send_item(12'd5, 16'd10, 1'b0);
        send_item(12'd5, 16'd10, 1'b1);
        settle();
        sets_sent++;

        // Capacity change inside a set: only the value at traceback counts.
        send_item(12'd3, 16'd7, 1'b0);
        settle();
        write_capacity(10'd2);
        send_item(12'd2, 16'd4, 1'b1);
        settle();
        sets_sent++;

        // Zero capacity: only the weightless item can be chosen.
        write_capacity(10'd0);
        send_item(12'd1, 16'd9, 1'b0);
        send_item(12'd0, 16'd3, 1'b1);
        settle();
        sets_sent++;

        // Small mixed set with several picks and running totals.
        write_capacity(10'd10);
        send_item(12'd4, 16'd40, 1'b0);
        send_item(12'd6, 16'd30, 1'b0);
        send_item(12'd3, 16'd50, 1'b0);
        send_item(12'd2, 16'd8, 1'b1);
        settle();
        sets_sent++;

        // ---------------- random sets ----------------
        while (items_sent < ITEM_GOAL) begin
            // Sender idles 30 %, then 61 %, then not at all.
            idle_pct = (items_sent < 140) ? 30 : (items_sent < 280) ? 61 : 0;

            case ($urandom_range(3))
                0: ;  // keep the current capacity
                1: write_capacity(CAP_W'($urandom_range(1023)));
                2: write_capacity(CAP_W'($urandom_range(63)));
                default: write_capacity($urandom_range(1) ? 10'd1023 : 10'd0);
            endcase

            set_kind = sets_sent % 12;
            if (set_kind == 4) begin
                set_len = $urandom_range(33, 35);  // overflow the item store
            end else if (set_kind == 9) begin
                set_len = MAX_ITEMS;               // weightless top values, max totals
            end else if ($urandom_range(5) == 0) begin
                set_len = $urandom_range(9, 31);
            end else begin
                set_len = $urandom_range(1, 8);
            end
            split_at = ($urandom_range(7) == 0 && set_len > 1) ? set_len / 2 : -1;

            for (int k = 0; k < set_len; k++) begin
                if (k == split_at) begin
                    // Drop the sender and move the capacity mid-set.
                    settle();
                    write_capacity(CAP_W'($urandom_range(1023)));
                end
                if (set_kind == 9) begin
                    w = '0;
                    v = 16'hFFFF;
                end else begin
                    case ($urandom_range(9))
                        0: w = WEIGHT_W'($urandom_range(4095));
                        1: w = '0;
                        2: w = WEIGHT_W'(cap_now);
                        default: w = WEIGHT_W'($urandom_range(int'(cap_now) / 4 + 1));
                    endcase
                    case ($urandom_range(9))
                        0: v = 16'hFFFF;
                        1: v = '0;
                        2: v = VALUE_W'($urandom_range(3));
                        default: v = VALUE_W'($urandom_range(65535));
                    endcase
                end
                send_item(w, v, k == set_len - 1);
            end
            settle();
            sets_sent++;
        end

        // Drain: watch for stray strobes through a full traceback and clear.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d item transactions in %0d sets with %0d capacity writes",
                 items_sent, sets_sent, cfg_writes);
        $display("Checked %0d result transactions, %0d with nothing chosen; %0d left over",
                 result_total, none_total, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #(64'd60_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: knapsack_dp_solver.f
sv/knp_pkg.sv
sv/knp_ram.sv
sv/knp_sweep.sv
sv/knp_trace.sv
sv/knapsack_dp_solver.sv
tb/sv/knapsack_checker.sv
tb/sv/testbench.sv
